@@ rtl/core/i2cmbe_pkg.sv @@
// Shared types, codes and the fixed bus program of the I2C master bit engine.
package i2cmbe_pkg;

   // Field widths
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned BIT_W   = 4;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned PHASE_W = 16;

   // Register reset values
   localparam logic [LIMIT_W-1:0] STRETCH_LIMIT_RESET = 8'd100;
   localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET   = 16'd1;

   // Program entry points and loop targets
   localparam logic [STEP_W-1:0] STEP_IDLE        = 6'd0;
   localparam logic [STEP_W-1:0] ENTRY_START      = 6'd1;
   localparam logic [STEP_W-1:0] ENTRY_STOP       = 6'd12;
   localparam logic [STEP_W-1:0] ENTRY_WRITE      = 6'd22;
   localparam logic [STEP_W-1:0] ENTRY_READ       = 6'd41;
   localparam logic [STEP_W-1:0] WRITE_LOOP_STEP  = 6'd30;
   localparam logic [STEP_W-1:0] READ_LOOP_TARGET = 6'd42;
   localparam logic [BIT_W-1:0]  BITS_PER_BYTE    = 4'd8;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_READ    = 3'd4,
      CMD_SET_SCL = 3'd5
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_STRETCH_LIMIT = 1'b0,
      CSR_PHASE_TICKS   = 1'b1
   } csr_index_type;

   // Program step operations
   typedef enum logic [3:0] {
      OP_END        = 4'd0,
      OP_SCL_REL    = 4'd1,
      OP_SCL_PULL   = 4'd2,
      OP_SDA_REL    = 4'd3,
      OP_SDA_PULL   = 4'd4,
      OP_SDA_BIT    = 4'd5,
      OP_SDA_ACK    = 4'd6,
      OP_SAMPLE_BIT = 4'd7,
      OP_SAMPLE_ACK = 4'd8,
      OP_LOOP       = 4'd9,
      OP_WAIT       = 4'd10,
      OP_STRETCH    = 4'd11
   } op_type;

   // One input beat
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] tx_byte;
      logic              ack_after_read;
      logic              scl_set_level;
      logic              scl_level;
      logic              sda_level;
   } req_item_type;

   // One result beat
   typedef struct packed {
      logic              scl_drive_low;
      logic              sda_drive_low;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] rx_data;
      logic              nack_received;
      logic              scl_now;
   } rsp_item_type;

   // Sequencer state touched by the zero-time program steps
   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [BIT_W-1:0]  bit_idx;
      logic [BYTE_W-1:0] shift;
      logic              scl_pull;
      logic              sda_pull;
      logic              nack;
   } seq_state_type;

   // Bus program: operation at each step, end at every unlisted step
   function automatic op_type prog_op(input logic [STEP_W-1:0] step);
      op_type op;
      case (step)
         6'd1, 6'd15, 6'd24, 6'd33, 6'd43, 6'd54:   op = OP_SCL_REL;
         6'd8, 6'd28, 6'd38, 6'd49, 6'd58:          op = OP_SCL_PULL;
         6'd2, 6'd18, 6'd31, 6'd41, 6'd60:          op = OP_SDA_REL;
         6'd5, 6'd12:                               op = OP_SDA_PULL;
         6'd22:                                     op = OP_SDA_BIT;
         6'd52:                                     op = OP_SDA_ACK;
         6'd47:                                     op = OP_SAMPLE_BIT;
         6'd37:                                     op = OP_SAMPLE_ACK;
         6'd30, 6'd51:                              op = OP_LOOP;
         6'd26, 6'd35, 6'd45, 6'd56:                op = OP_STRETCH;
         6'd3, 6'd4, 6'd6, 6'd7, 6'd9, 6'd10, 6'd13, 6'd14, 6'd16, 6'd17,
         6'd19, 6'd20, 6'd23, 6'd25, 6'd27, 6'd29, 6'd32, 6'd34, 6'd36,
         6'd39, 6'd42, 6'd44, 6'd46, 6'd48, 6'd50, 6'd53, 6'd55, 6'd57,
         6'd59:                                     op = OP_WAIT;
         default:                                   op = OP_END;
      endcase
      return op;
   endfunction

   // Jump target of a bit loop step
   function automatic logic [STEP_W-1:0] prog_target(input logic [STEP_W-1:0] step);
      return (step == WRITE_LOOP_STEP) ? ENTRY_WRITE : READ_LOOP_TARGET;
   endfunction

   // One zero-time program step; timed steps and the end leave the state alone
   function automatic seq_state_type zero_step(input seq_state_type s,
                                               input logic          ack,
                                               input logic          sda);
      seq_state_type     r;
      logic [STEP_W-1:0] nxt;
      logic [BIT_W-1:0]  bi;
      r   = s;
      nxt = s.step + 6'd1;
      bi  = s.bit_idx + 4'd1;
      case (prog_op(s.step))
         OP_SCL_REL:    r.scl_pull = 1'b0;
         OP_SCL_PULL:   r.scl_pull = 1'b1;
         OP_SDA_REL:    r.sda_pull = 1'b0;
         OP_SDA_PULL:   r.sda_pull = 1'b1;
         OP_SDA_BIT: begin
            r.sda_pull = ~s.shift[BYTE_W-1];
            r.shift    = {s.shift[BYTE_W-2:0], 1'b0};
         end
         OP_SDA_ACK:    r.sda_pull = ack;
         OP_SAMPLE_BIT: r.shift    = {s.shift[BYTE_W-2:0], sda};
         OP_SAMPLE_ACK: r.nack     = sda;
         OP_LOOP: begin
            r.bit_idx = bi;
            if (bi < BITS_PER_BYTE) nxt = prog_target(s.step);
         end
         default:       nxt = s.step;
      endcase
      r.step = nxt;
      return r;
   endfunction

   // Zero-time runs in the program are at most three steps long
   function automatic seq_state_type run_zero(input seq_state_type s,
                                              input logic          ack,
                                              input logic          sda);
      seq_state_type r;
      r = zero_step(s, ack, sda);
      r = zero_step(r, ack, sda);
      r = zero_step(r, ack, sda);
      return r;
   endfunction

endpackage

@@ rtl/core/i2c_master_bit_engine_top.sv @@
// Top level of the I2C master bit engine: beat registers, handshakes, CSRs.
// A request beat is registered, then moves into the response register when that
// is free or being drained. One tick beat per cycle unless rsp_ready stalls; the
// sequencer state advances once per beat, from request into response register.
// Reset: synchronous; clears the sequencer to idle with both lines released,
// stretch_limit to 100 and phase_ticks to 1.
module i2c_master_bit_engine_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [i2cmbe_pkg::CMD_W-1:0]      req_command,
   input  logic [i2cmbe_pkg::BYTE_W-1:0]     req_tx_byte,
   input  logic                              req_ack_after_read,
   input  logic                              req_scl_set_level,
   input  logic                              req_scl_level,
   input  logic                              req_sda_level,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_scl_drive_low,
   output logic                              rsp_sda_drive_low,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic [i2cmbe_pkg::BYTE_W-1:0]     rsp_rx_data,
   output logic                              rsp_nack_received,
   output logic                              rsp_scl_now,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_index,
   input  logic [i2cmbe_pkg::PHASE_W-1:0]    csr_wdata
);

   logic                           req_valid_ff, req_valid_in;
   i2cmbe_pkg::req_item_type       req_item_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   i2cmbe_pkg::rsp_item_type       rsp_item_ff;
   i2cmbe_pkg::rsp_item_type       step_result;
   logic                           advance;
   logic [i2cmbe_pkg::LIMIT_W-1:0] stretch_limit;
   logic [i2cmbe_pkg::PHASE_W-1:0] phase_ticks;

   i2cmbe_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .stretch_limit (stretch_limit),
      .phase_ticks   (phase_ticks)
   );

   // Beat moves on when the response register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   i2cmbe_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .tick          (advance),
      .item          (req_item_ff),
      .stretch_limit (stretch_limit),
      .phase_ticks   (phase_ticks),
      .result        (step_result)
   );

   // Valid flags
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) req_valid_in = 1'b1;
      else if (advance)           req_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance)        rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_item_ff.command        <= req_command;
         req_item_ff.tx_byte        <= req_tx_byte;
         req_item_ff.ack_after_read <= req_ack_after_read;
         req_item_ff.scl_set_level  <= req_scl_set_level;
         req_item_ff.scl_level      <= req_scl_level;
         req_item_ff.sda_level      <= req_sda_level;
      end
      if (advance) rsp_item_ff <= step_result;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scl_drive_low = rsp_item_ff.scl_drive_low;
   assign rsp_sda_drive_low = rsp_item_ff.sda_drive_low;
   assign rsp_busy_res      = rsp_item_ff.busy_res;
   assign rsp_done_res      = rsp_item_ff.done_res;
   assign rsp_rx_data       = rsp_item_ff.rx_data;
   assign rsp_nack_received = rsp_item_ff.nack_received;
   assign rsp_scl_now       = rsp_item_ff.scl_now;

endmodule

@@ rtl/core/i2cmbe_csr.sv @@
// Configuration registers: clock stretch limit and ticks per delay step.
module i2cmbe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [i2cmbe_pkg::PHASE_W-1:0]      csr_wdata,
   output logic [i2cmbe_pkg::LIMIT_W-1:0]      stretch_limit,
   output logic [i2cmbe_pkg::PHASE_W-1:0]      phase_ticks
);

   logic [i2cmbe_pkg::LIMIT_W-1:0] stretch_limit_ff, stretch_limit_in;
   logic [i2cmbe_pkg::PHASE_W-1:0] phase_ticks_ff, phase_ticks_in;

   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      stretch_limit_in = stretch_limit_ff;
      phase_ticks_in   = phase_ticks_ff;
      if (csr_valid) begin
         case (csr_index)
            i2cmbe_pkg::CSR_STRETCH_LIMIT:
               stretch_limit_in = csr_wdata[i2cmbe_pkg::LIMIT_W-1:0];
            i2cmbe_pkg::CSR_PHASE_TICKS:
               phase_ticks_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stretch_limit_ff <= i2cmbe_pkg::STRETCH_LIMIT_RESET;
         phase_ticks_ff   <= i2cmbe_pkg::PHASE_TICKS_RESET;
      end else begin
         stretch_limit_ff <= stretch_limit_in;
         phase_ticks_ff   <= phase_ticks_in;
      end
   end

   assign stretch_limit = stretch_limit_ff;
   assign phase_ticks   = phase_ticks_ff;

endmodule

@@ rtl/core/i2cmbe_engine.sv @@
// Bus sequencer: state registers and the per-tick step logic.
module i2cmbe_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            tick,
   input  i2cmbe_pkg::req_item_type        item,
   input  logic [i2cmbe_pkg::LIMIT_W-1:0]  stretch_limit,
   input  logic [i2cmbe_pkg::PHASE_W-1:0]  phase_ticks,
   output i2cmbe_pkg::rsp_item_type        result
);

   i2cmbe_pkg::seq_state_type         seq_ff, seq_in;
   logic [i2cmbe_pkg::PHASE_W-1:0]    delay_left_ff, delay_left_in;
   logic [i2cmbe_pkg::LIMIT_W-1:0]    stretch_wait_ff, stretch_wait_in;
   logic [i2cmbe_pkg::CMD_W-1:0]      cur_op_ff, cur_op_in;
   logic                              ack_choice_ff, ack_choice_in;
   logic [i2cmbe_pkg::BYTE_W-1:0]     rx_hold_ff, rx_hold_in;
   logic [i2cmbe_pkg::PHASE_W-1:0]    delay_load;
   logic                              done;
   logic                              complete;
   i2cmbe_pkg::op_type                op_now;
   i2cmbe_pkg::op_type                op_land;

   // Zero phase_ticks still gives a one tick delay
   assign delay_load = (phase_ticks == '0) ? 16'd1 : phase_ticks;

   // One tick of the sequencer
   always_comb begin
      seq_in          = seq_ff;
      delay_left_in   = delay_left_ff;
      stretch_wait_in = stretch_wait_ff;
      cur_op_in       = cur_op_ff;
      ack_choice_in   = ack_choice_ff;
      rx_hold_in      = rx_hold_ff;
      done            = 1'b0;
      complete        = 1'b1;
      op_land         = i2cmbe_pkg::OP_END;

      // Idle: take a command
      if (seq_ff.step == i2cmbe_pkg::STEP_IDLE) begin
         if (item.command == i2cmbe_pkg::CMD_SET_SCL) begin
            seq_in.scl_pull = ~item.scl_set_level;
            done            = 1'b1;
         end else if (item.command == i2cmbe_pkg::CMD_START ||
                      item.command == i2cmbe_pkg::CMD_STOP  ||
                      item.command == i2cmbe_pkg::CMD_WRITE ||
                      item.command == i2cmbe_pkg::CMD_READ) begin
            cur_op_in       = item.command;
            ack_choice_in   = item.ack_after_read;
            seq_in.bit_idx  = '0;
            seq_in.shift    = (item.command == i2cmbe_pkg::CMD_WRITE) ? item.tx_byte : '0;
            case (item.command)
               i2cmbe_pkg::CMD_START: seq_in.step = i2cmbe_pkg::ENTRY_START;
               i2cmbe_pkg::CMD_STOP:  seq_in.step = i2cmbe_pkg::ENTRY_STOP;
               i2cmbe_pkg::CMD_WRITE: seq_in.step = i2cmbe_pkg::ENTRY_WRITE;
               default:               seq_in.step = i2cmbe_pkg::ENTRY_READ;
            endcase
            seq_in  = i2cmbe_pkg::run_zero(seq_in, ack_choice_in, item.sda_level);
            op_land = i2cmbe_pkg::prog_op(seq_in.step);
            if (op_land == i2cmbe_pkg::OP_WAIT)         delay_left_in   = delay_load;
            else if (op_land == i2cmbe_pkg::OP_STRETCH) stretch_wait_in = '0;
         end
      end

      op_now = i2cmbe_pkg::prog_op(seq_in.step);

      // Timed step in progress
      if (seq_in.step != i2cmbe_pkg::STEP_IDLE) begin
         if (op_now == i2cmbe_pkg::OP_WAIT) begin
            if (delay_left_in > 16'd1) begin
               delay_left_in = delay_left_in - 16'd1;
               complete      = 1'b0;
            end else begin
               delay_left_in = '0;
            end
         end else if (op_now == i2cmbe_pkg::OP_STRETCH) begin
            if (!item.scl_level && stretch_wait_in < stretch_limit) begin
               stretch_wait_in = stretch_wait_in + 8'd1;
               complete        = 1'b0;
            end
         end

         // Step done: advance through the following zero-time steps
         if (complete && (op_now == i2cmbe_pkg::OP_WAIT ||
                          op_now == i2cmbe_pkg::OP_STRETCH)) begin
            seq_in.step = seq_in.step + 6'd1;
            seq_in      = i2cmbe_pkg::run_zero(seq_in, ack_choice_in, item.sda_level);
            op_land     = i2cmbe_pkg::prog_op(seq_in.step);
            if (op_land == i2cmbe_pkg::OP_WAIT)         delay_left_in   = delay_load;
            else if (op_land == i2cmbe_pkg::OP_STRETCH) stretch_wait_in = '0;
         end

         // End of the program
         if (i2cmbe_pkg::prog_op(seq_in.step) == i2cmbe_pkg::OP_END) begin
            if (cur_op_in == i2cmbe_pkg::CMD_READ) rx_hold_in = seq_in.shift;
            seq_in.step = i2cmbe_pkg::STEP_IDLE;
            cur_op_in   = i2cmbe_pkg::CMD_NONE;
            done        = 1'b1;
         end
      end
   end

   // Result of this tick
   always_comb begin
      result.scl_drive_low = seq_in.scl_pull;
      result.sda_drive_low = seq_in.sda_pull;
      result.busy_res      = (seq_in.step != i2cmbe_pkg::STEP_IDLE);
      result.done_res      = done;
      result.rx_data       = rx_hold_in;
      result.nack_received = seq_in.nack;
      result.scl_now       = item.scl_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff          <= '0;
         delay_left_ff   <= '0;
         stretch_wait_ff <= '0;
         cur_op_ff       <= i2cmbe_pkg::CMD_NONE;
         ack_choice_ff   <= 1'b0;
         rx_hold_ff      <= '0;
      end else if (tick) begin
         seq_ff          <= seq_in;
         delay_left_ff   <= delay_left_in;
         stretch_wait_ff <= stretch_wait_in;
         cur_op_ff       <= cur_op_in;
         ack_choice_ff   <= ack_choice_in;
         rx_hold_ff      <= rx_hold_in;
      end
   end

endmodule

@@ tb/i2cmbe_tick_scoreboard.sv @@
// Scoreboard for the I2C master bit engine: tracks CSR writes, predicts each tick, checks responses.
`timescale 1ns / 1ps

module i2cmbe_tick_scoreboard (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [i2cmbe_pkg::CMD_W-1:0]  req_command,
   input  logic [i2cmbe_pkg::BYTE_W-1:0] req_tx_byte,
   input  logic                          req_ack_after_read,
   input  logic                          req_scl_set_level,
   input  logic                          req_scl_level,
   input  logic                          req_sda_level,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_scl_drive_low,
   input  logic                          rsp_sda_drive_low,
   input  logic                          rsp_busy_res,
   input  logic                          rsp_done_res,
   input  logic [i2cmbe_pkg::BYTE_W-1:0] rsp_rx_data,
   input  logic                          rsp_nack_received,
   input  logic                          rsp_scl_now,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [i2cmbe_pkg::PHASE_W-1:0] csr_wdata,
   output int unsigned                   mismatch_count,
   output int unsigned                   pending_count
);
   import i2cmbe_pkg::*;

   localparam int unsigned REPORT_MAX = 10;

   // Shadow of the sequencer and its registers
   logic [STEP_W-1:0]  step_q;
   logic [BIT_W-1:0]   bits_done;
   logic [BYTE_W-1:0]  shift_reg;
   logic [LIMIT_W-1:0] stretch_cnt;
   logic [PHASE_W-1:0] delay_cnt;
   logic [CMD_W-1:0]   active_cmd;
   logic               scl_low;
   logic               sda_low;
   logic               ack_sel;
   logic               nack_seen;
   logic [BYTE_W-1:0]  rx_byte;
   logic [LIMIT_W-1:0] limit_reg;
   logic [PHASE_W-1:0] phase_reg;

   rsp_item_type pin_state_queue [$];

   // Bus program, one operation per step
   function automatic op_type step_op(input logic [STEP_W-1:0] s);
      op_type op;
      case (s)
         // start condition
         6'd1:                                   op = OP_SCL_REL;
         6'd2:                                   op = OP_SDA_REL;
         6'd5:                                   op = OP_SDA_PULL;
         6'd8:                                   op = OP_SCL_PULL;
         6'd3, 6'd4, 6'd6, 6'd7, 6'd9, 6'd10:    op = OP_WAIT;
         // stop condition
         6'd12:                                  op = OP_SDA_PULL;
         6'd15:                                  op = OP_SCL_REL;
         6'd18:                                  op = OP_SDA_REL;
         6'd13, 6'd14, 6'd16, 6'd17, 6'd19, 6'd20: op = OP_WAIT;
         // byte write, then ack slot
         6'd22:                                  op = OP_SDA_BIT;
         6'd24, 6'd33:                           op = OP_SCL_REL;
         6'd26, 6'd35:                           op = OP_STRETCH;
         6'd28, 6'd38:                           op = OP_SCL_PULL;
         6'd30:                                  op = OP_LOOP;
         6'd31:                                  op = OP_SDA_REL;
         6'd37:                                  op = OP_SAMPLE_ACK;
         6'd23, 6'd25, 6'd27, 6'd29, 6'd32, 6'd34, 6'd36, 6'd39: op = OP_WAIT;
         // byte read, then ack drive
         6'd41, 6'd60:                           op = OP_SDA_REL;
         6'd43, 6'd54:                           op = OP_SCL_REL;
         6'd45, 6'd56:                           op = OP_STRETCH;
         6'd47:                                  op = OP_SAMPLE_BIT;
         6'd49, 6'd58:                           op = OP_SCL_PULL;
         6'd51:                                  op = OP_LOOP;
         6'd52:                                  op = OP_SDA_ACK;
         6'd42, 6'd44, 6'd46, 6'd48, 6'd50, 6'd53, 6'd55, 6'd57, 6'd59: op = OP_WAIT;
         default:                                op = OP_END;
      endcase
      return op;
   endfunction

   // Move to a step and arm its timer
   task automatic goto_step(input logic [STEP_W-1:0] s);
      step_q = s;
      if (step_op(s) == OP_WAIT)
         delay_cnt = (phase_reg == '0) ? 16'd1 : phase_reg;
      else if (step_op(s) == OP_STRETCH)
         stretch_cnt = '0;
   endtask

   // Execute pin actions and samples until a timed step or the end
   task automatic run_instant_steps(input logic sda);
      logic [STEP_W-1:0] nxt;
      logic              more;
      int                guard;
      more = 1'b1;
      for (guard = 0; guard < 124 && more; guard++) begin
         nxt = step_q + 6'd1;
         case (step_op(step_q))
            OP_SCL_REL:    scl_low = 1'b0;
            OP_SCL_PULL:   scl_low = 1'b1;
            OP_SDA_REL:    sda_low = 1'b0;
            OP_SDA_PULL:   sda_low = 1'b1;
            OP_SDA_BIT: begin
               sda_low   = ~shift_reg[BYTE_W-1];
               shift_reg = {shift_reg[BYTE_W-2:0], 1'b0};
            end
            OP_SDA_ACK:    sda_low = ack_sel;
            OP_SAMPLE_BIT: shift_reg = {shift_reg[BYTE_W-2:0], sda};
            OP_SAMPLE_ACK: nack_seen = sda;
            OP_LOOP: begin
               bits_done = bits_done + 4'd1;
               if (bits_done < BITS_PER_BYTE)
                  nxt = (step_q == WRITE_LOOP_STEP) ? ENTRY_WRITE : READ_LOOP_TARGET;
            end
            default:       more = 1'b0;
         endcase
         if (more)
            goto_step(nxt);
      end
   endtask

   // One tick of the sequencer: returns the pin state after the tick
   task automatic predict_bus_tick(input  logic [CMD_W-1:0]  cmd,
                                   input  logic [BYTE_W-1:0] tx,
                                   input  logic              ack,
                                   input  logic              scl_set,
                                   input  logic              scl,
                                   input  logic              sda,
                                   output rsp_item_type      want);
      op_type op;
      logic   finished;
      logic   done;
      done = 1'b0;

      // command decode, idle only
      if (step_q == STEP_IDLE) begin
         if (cmd == CMD_SET_SCL) begin
            scl_low = ~scl_set;
            done    = 1'b1;
         end else if (cmd >= CMD_START && cmd <= CMD_READ) begin
            active_cmd = cmd;
            bits_done  = '0;
            shift_reg  = (cmd == CMD_WRITE) ? tx : '0;
            ack_sel    = ack;
            case (cmd)
               CMD_START: goto_step(ENTRY_START);
               CMD_STOP:  goto_step(ENTRY_STOP);
               CMD_WRITE: goto_step(ENTRY_WRITE);
               default:   goto_step(ENTRY_READ);
            endcase
            run_instant_steps(sda);
         end
      end

      // timed step of this tick
      if (step_q != STEP_IDLE) begin
         op       = step_op(step_q);
         finished = 1'b1;
         if (op == OP_WAIT) begin
            if (delay_cnt > 16'd1) begin
               delay_cnt = delay_cnt - 16'd1;
               finished  = 1'b0;
            end else begin
               delay_cnt = '0;
            end
         end else if (op == OP_STRETCH) begin
            if (!scl && stretch_cnt < limit_reg) begin
               stretch_cnt = stretch_cnt + 8'd1;
               finished    = 1'b0;
            end
         end
         if (finished && (op == OP_WAIT || op == OP_STRETCH)) begin
            goto_step(step_q + 6'd1);
            run_instant_steps(sda);
         end
         if (step_op(step_q) == OP_END) begin
            if (active_cmd == CMD_READ)
               rx_byte = shift_reg;
            step_q     = STEP_IDLE;
            active_cmd = CMD_NONE;
            done       = 1'b1;
         end
      end

      want.scl_drive_low = scl_low;
      want.sda_drive_low = sda_low;
      want.busy_res      = (step_q != STEP_IDLE);
      want.done_res      = done;
      want.rx_data       = rx_byte;
      want.nack_received = nack_seen;
      want.scl_now       = scl;
   endtask

   // Watch all three channels on each edge
   always @(posedge clock) begin : watch
      rsp_item_type got;
      rsp_item_type want;
      rsp_item_type next_pins;
      if (reset) begin
         step_q      = STEP_IDLE;
         bits_done   = '0;
         shift_reg   = '0;
         stretch_cnt = '0;
         delay_cnt   = '0;
         active_cmd  = CMD_NONE;
         scl_low     = 1'b0;
         sda_low     = 1'b0;
         ack_sel     = 1'b0;
         nack_seen   = 1'b0;
         rx_byte     = '0;
         limit_reg   = STRETCH_LIMIT_RESET;
         phase_reg   = PHASE_TICKS_RESET;
         mismatch_count = 0;
         pin_state_queue.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_STRETCH_LIMIT)
               limit_reg = csr_wdata[LIMIT_W-1:0];
            else
               phase_reg = csr_wdata;
         end

         // response beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.scl_drive_low = rsp_scl_drive_low;
            got.sda_drive_low = rsp_sda_drive_low;
            got.busy_res      = rsp_busy_res;
            got.done_res      = rsp_done_res;
            got.rx_data       = rsp_rx_data;
            got.nack_received = rsp_nack_received;
            got.scl_now       = rsp_scl_now;
            if (pin_state_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: response beat with no tick pending: %p", $time, got);
            end else begin
               want = pin_state_queue.pop_front();
               if (got.scl_drive_low !== want.scl_drive_low ||
                   got.sda_drive_low !== want.sda_drive_low ||
                   got.busy_res      !== want.busy_res ||
                   got.done_res      !== want.done_res ||
                   got.rx_data       !== want.rx_data ||
                   got.nack_received !== want.nack_received ||
                   got.scl_now       !== want.scl_now) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("%0t: mismatch exp scl_low=%b sda_low=%b busy=%b done=%b",
                              $time, want.scl_drive_low, want.sda_drive_low,
                              want.busy_res, want.done_res,
                              " rx=%h nack=%b scl=%b | got scl_low=%b sda_low=%b",
                              want.rx_data, want.nack_received, want.scl_now,
                              got.scl_drive_low, got.sda_drive_low,
                              " busy=%b done=%b rx=%h nack=%b scl=%b",
                              got.busy_res, got.done_res, got.rx_data,
                              got.nack_received, got.scl_now);
               end
            end
         end

         // new tick beat
         if (req_valid && req_ready) begin
            predict_bus_tick(req_command, req_tx_byte, req_ack_after_read,
                             req_scl_set_level, req_scl_level, req_sda_level, next_pins);
            pin_state_queue.push_back(next_pins);
         end
      end
      pending_count <= pin_state_queue.size();
   end

endmodule

@@ tb/i2c_master_bit_engine_top_tb.sv @@
// Top testbench of the I2C master bit engine: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module i2c_master_bit_engine_top_tb;
   import i2cmbe_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DONE_TIMEOUT = 8000;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command        = CMD_NONE;
   logic [BYTE_W-1:0]   req_tx_byte        = '0;
   logic                req_ack_after_read = 1'b0;
   logic                req_scl_set_level  = 1'b0;
   logic                req_scl_level      = 1'b1;
   logic                req_sda_level      = 1'b1;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic                rsp_scl_drive_low;
   logic                rsp_sda_drive_low;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic [BYTE_W-1:0]   rsp_rx_data;
   logic                rsp_nack_received;
   logic                rsp_scl_now;
   logic                csr_valid          = 1'b0;
   logic                csr_ready;
   logic [0:0]          csr_index          = CSR_STRETCH_LIMIT;
   logic [PHASE_W-1:0]  csr_wdata          = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;

   // stimulus bookkeeping
   int          burst_left  = 0;
   int          items_sent  = 0;
   int          done_beats  = 0;
   logic        bus_busy    = 1'b0;
   int          quiet_cycles = 0;
   int          stall_left  = 0;
   int          stall_mode  = 0;
   // slave side: clock stretching profile
   int          low_pct     = 0;
   int          max_run     = 1;
   int          low_run     = 0;
   int          limit_now   = 100;

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   i2c_master_bit_engine_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_tx_byte        (req_tx_byte),
      .req_ack_after_read (req_ack_after_read),
      .req_scl_set_level  (req_scl_set_level),
      .req_scl_level      (req_scl_level),
      .req_sda_level      (req_sda_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_drive_low  (rsp_scl_drive_low),
      .rsp_sda_drive_low  (rsp_sda_drive_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rx_data        (rsp_rx_data),
      .rsp_nack_received  (rsp_nack_received),
      .rsp_scl_now        (rsp_scl_now),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   i2cmbe_tick_scoreboard i_scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_tx_byte        (req_tx_byte),
      .req_ack_after_read (req_ack_after_read),
      .req_scl_set_level  (req_scl_set_level),
      .req_scl_level      (req_scl_level),
      .req_sda_level      (req_sda_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_drive_low  (rsp_scl_drive_low),
      .rsp_sda_drive_low  (rsp_sda_drive_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rx_data        (rsp_rx_data),
      .rsp_nack_received  (rsp_nack_received),
      .rsp_scl_now        (rsp_scl_now),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // Random field values at field width
   function automatic logic [BYTE_W-1:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [CMD_W-1:0] rand_cmd();
      return 3'($urandom_range(0, 7));
   endfunction

   // Receiver: stall pattern changes mode every so often
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= rand_bit();
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   // Track sequence completion and busy from accepted response beats
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (rsp_done_res)
            done_beats <= done_beats + 1;
         bus_busy <= rsp_busy_res;
      end
   end

   // Watchdog: no beat on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One tick beat, with burst/gap pacing
   task automatic send_tick(input logic [CMD_W-1:0]  cmd,
                            input logic [BYTE_W-1:0] tx,
                            input logic              ack,
                            input logic              scl_set,
                            input logic              scl,
                            input logic              sda);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_tx_byte        <= tx;
      req_ack_after_read <= ack;
      req_scl_set_level  <= scl_set;
      req_scl_level      <= scl;
      req_sda_level      <= sda;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Slave side levels: SCL held low in runs, SDA random
   task automatic bus_tick(input logic [CMD_W-1:0]  cmd,
                           input logic [BYTE_W-1:0] tx,
                           input logic              ack,
                           input logic              scl_set);
      logic scl;
      logic sda;
      if (low_run > 0) begin
         scl = 1'b0;
         low_run--;
      end else if ($urandom_range(0, 99) < low_pct) begin
         scl     = 1'b0;
         low_run = $urandom_range(0, max_run);
      end else begin
         scl = 1'b1;
      end
      sda = rand_bit();
      send_tick(cmd, tx, ack, scl_set, scl, sda);
   endtask

   // Idle ticks with random don't-care fields until a sequence reports done
   task automatic wait_done(input int start_done);
      int waited;
      waited = 0;
      while (done_beats == start_done && waited < DONE_TIMEOUT) begin
         bus_tick(CMD_NONE, rand_byte(), rand_bit(), rand_bit());
         waited++;
      end
   endtask

   task automatic run_command(input logic [CMD_W-1:0]  cmd,
                              input logic [BYTE_W-1:0] tx,
                              input logic              ack,
                              input logic              scl_set);
      int start_done;
      start_done = done_beats;
      bus_tick(cmd, tx, ack, scl_set);
      wait_done(start_done);
   endtask

   // Hold the sender until every predicted beat has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Drain, then finish any sequence still running
   task automatic settle_bus();
      drain_responses();
      while (bus_busy) begin
         repeat (8) bus_tick(CMD_NONE, rand_byte(), rand_bit(), rand_bit());
         drain_responses();
      end
   endtask

   // Write both registers; upper data bits are junk for the 8-bit one
   task automatic write_regs(input int limit, input int ticks);
      logic [7:0] junk;
      junk      = rand_byte();
      limit_now = limit;
      csr_valid <= 1'b1;
      csr_index <= CSR_STRETCH_LIMIT;
      csr_wdata <= {junk, limit[7:0]};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= ticks[15:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Transfer: start, one to four writes, reads, restarts or SCL sets, then usually stop
   task automatic bus_transaction();
      int n;
      run_command(CMD_START, rand_byte(), rand_bit(), rand_bit());
      n = $urandom_range(1, 4);
      repeat (n) begin
         case ($urandom_range(0, 6))
            0, 1, 2: run_command(CMD_WRITE, rand_byte(), rand_bit(), rand_bit());
            3, 4:    run_command(CMD_READ, rand_byte(), rand_bit(), rand_bit());
            5:       run_command(CMD_START, rand_byte(), rand_bit(), rand_bit());
            default: run_command(CMD_SET_SCL, rand_byte(), rand_bit(), rand_bit());
         endcase
      end
      if ($urandom_range(0, 7) != 0)
         run_command(CMD_STOP, rand_byte(), rand_bit(), rand_bit());
   endtask

   // Random commands at any time, busy or not, spare codes included
   task automatic noise_burst();
      int n;
      n = $urandom_range(5, 30);
      repeat (n) bus_tick(rand_cmd(), rand_byte(), rand_bit(), rand_bit());
      settle_bus();
   endtask

   initial begin : stimulus
      int ph;
      int lim;
      int ticks;
      int phase_start;
      int start_done;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset-value registers, every command and the corner bytes
      write_regs(int'(STRETCH_LIMIT_RESET), int'(PHASE_TICKS_RESET));
      low_pct = 0;
      bus_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
      bus_tick(CMD_SPARE_6, 8'hFF, 1'b1, 1'b1);
      bus_tick(CMD_SPARE_7, 8'h00, 1'b0, 1'b0);
      run_command(CMD_SET_SCL, 8'h00, 1'b0, 1'b0);
      run_command(CMD_SET_SCL, 8'hFF, 1'b1, 1'b1);
      run_command(CMD_START, 8'h00, 1'b0, 1'b0);
      run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
      run_command(CMD_WRITE, 8'h00, 1'b1, 1'b1);
      run_command(CMD_READ, 8'h00, 1'b1, 1'b0);
      run_command(CMD_READ, 8'hFF, 1'b0, 1'b1);
      run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
      // commands while busy are dropped
      start_done = done_beats;
      bus_tick(CMD_START, 8'h5A, 1'b1, 1'b0);
      bus_tick(CMD_WRITE, 8'hA5, 1'b1, 1'b0);
      bus_tick(CMD_SET_SCL, 8'h00, 1'b0, 1'b0);
      bus_tick(CMD_READ, 8'h00, 1'b1, 1'b1);
      wait_done(start_done);
      run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);

      // zero registers: every delay and stretch lasts one tick, SCL held low
      settle_bus();
      write_regs(0, 0);
      low_pct = 100;
      max_run = 50;
      run_command(CMD_START, 8'h00, 1'b0, 1'b0);
      run_command(CMD_WRITE, 8'hC3, 1'b0, 1'b0);
      run_command(CMD_READ, 8'h00, 1'b1, 1'b0);
      run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);

      // short stretch limit: timeouts under a stuck SCL, then short stretches
      settle_bus();
      low_run = 0;
      write_regs(6, 1);
      run_command(CMD_START, 8'h00, 1'b0, 1'b0);
      run_command(CMD_WRITE, 8'h3C, 1'b0, 1'b0);
      low_pct = 30;
      max_run = 9;
      run_command(CMD_READ, 8'h00, 1'b0, 1'b0);
      run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);

      // random phases with mixed register settings
      for (ph = 0; ph < 5; ph++) begin
         settle_bus();
         case ($urandom_range(0, 3))
            0:       lim = 0;
            1:       lim = 255;
            default: lim = $urandom_range(1, 30);
         endcase
         ticks = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
         write_regs(lim, ticks);
         phase_start = items_sent;
         while (items_sent - phase_start < 300) begin
            case ($urandom_range(0, 3))
               0:       low_pct = 0;
               1:       low_pct = 10;
               2:       low_pct = 40;
               default: low_pct = $urandom_range(0, 100);
            endcase
            max_run = ($urandom_range(0, 3) == 0 && limit_now < 40) ? limit_now + 3
                                                                   : $urandom_range(1, 8);
            low_run = 0;
            if ($urandom_range(0, 9) < 7)
               bus_transaction();
            else
               noise_burst();
         end
      end

      // largest settings: a start that stays in its first delay
      settle_bus();
      write_regs(255, 65535);
      low_pct = 0;
      low_run = 0;
      bus_tick(CMD_START, 8'h00, 1'b0, 1'b0);
      repeat (150) bus_tick(rand_cmd(), rand_byte(), rand_bit(), rand_bit());

      drain_responses();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ i2c_master_bit_engine_top.f @@
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_csr.sv
rtl/core/i2cmbe_engine.sv
rtl/core/i2c_master_bit_engine_top.sv
tb/i2cmbe_tick_scoreboard.sv
tb/i2c_master_bit_engine_top_tb.sv
